// ===== sv/ptm_pkg.sv =====
// shared types, constants and reset table of the page table mapper
package ptm_pkg;

  localparam int PoolFrames = 256;
  localparam int FrameIdxW  = $clog2(PoolFrames);
  localparam int NextFreeW  = $clog2(PoolFrames + 1);
  localparam int DirDepth   = 1024;
  localparam int DirIdxW    = $clog2(DirDepth);
  localparam int TableWords = 1024;
  localparam int TblAddrW   = FrameIdxW + DirIdxW;
  localparam int TblDepth   = PoolFrames * TableWords;
  localparam int PfnW       = 20;
  localparam int IdentSlots = 256;

  localparam logic [31:0]        LargePageFlags = 32'h0000_0183;
  localparam logic [31:0]        TableFlags     = 32'h0000_0005;
  localparam logic [31:0]        PdeFlags       = 32'h0000_0007;
  localparam logic [DirIdxW-1:0] LastSlot       = DirIdxW'(DirDepth - 1);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_MAP   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_MAPPED = 2'd2,
    ST_BADPDE = 2'd3
  } status_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic        writable;
  } ptm_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] frame_addr;
    logic [31:0] entry_value;
  } ptm_rsp_t;

  typedef struct packed {
    logic                 full;
    logic [FrameIdxW-1:0] frame;
    logic [31:0]          addr;
    logic                 pde_ok;
    logic [FrameIdxW-1:0] pde_frame;
  } alloc_info_t;

  function automatic logic [31:0] dir_reset_value(logic [DirIdxW-1:0] idx);
    logic [31:0] val;
    val = '0;
    if (32'(idx) < IdentSlots) begin
      val = {idx, 22'h0} | LargePageFlags;
    end else if (idx == LastSlot) begin
      val = LargePageFlags;
    end
    return val;
  endfunction

endpackage

// ===== sv/ptm_ram.sv =====
// generic single-clock ram with one write port and a registered read port
module ptm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ptm_alloc.sv =====
// frame allocator: next free counter, frame address and pool range check
module ptm_alloc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [31:0]           pool_base_i,
  input  logic [31:0]           pde_i,
  output ptm_pkg::alloc_info_t  info_o
);
  import ptm_pkg::*;

  logic [NextFreeW-1:0] next_free_q, next_free_d;
  logic [PfnW-1:0]      diff;

  assign next_free_d = take_i ? next_free_q + NextFreeW'(1) : next_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= NextFreeW'(1);
    end else begin
      next_free_q <= next_free_d;
    end
  end

  assign diff = pde_i[31:12] - pool_base_i[31:12];

  always_comb begin
    info_o.full      = next_free_q >= NextFreeW'(PoolFrames);
    info_o.frame     = next_free_q[FrameIdxW-1:0];
    info_o.addr      = {pool_base_i[31:12] + PfnW'(next_free_q), 12'h000};
    info_o.pde_ok    = (diff != '0) && (diff < PfnW'(next_free_q)) &&
                       (diff < PfnW'(PoolFrames));
    info_o.pde_frame = diff[FrameIdxW-1:0];
  end

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= NextFreeW'(PoolFrames))
    else $error("next free frame beyond pool");

  a_nf_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_free_q != $past(next_free_q)) |->
      (next_free_q == $past(next_free_q) + NextFreeW'(1)))
    else $error("next free frame moved by more than one");

endmodule

// ===== sv/page_table_mapper_core.sv =====
// page table mapper top level: request sequencer over directory and table rams
// sequence: an allocate answers on done_o in the cycle after start; a map of an existing table
//   runs directory read, table read and table write-back over registered-read rams
// a map that creates a table first clears all 1024 table words, one word per cycle
// throughput: allocates every cycle, maps one at a time; start is taken only while busy is low
// reset: the directory is rewritten to its boot layout with busy high
// done_o is a one-cycle strobe; the receiver cannot stall results
module page_table_mapper_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ptm_pkg::ptm_req_t req_i,
  output logic              done_o,
  output ptm_pkg::ptm_rsp_t rsp_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i
);
  import ptm_pkg::*;

  typedef enum logic [5:0] {
    S_INIT    = 6'b000001,
    S_IDLE    = 6'b000010,
    S_DIR_CHK = 6'b000100,
    S_CLEAR   = 6'b001000,
    S_TBL_RD  = 6'b010000,
    S_TBL_CHK = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [DirIdxW-1:0]   cnt_q, cnt_d;
  ptm_req_t             req_q, req_d;
  logic [FrameIdxW-1:0] frame_q, frame_d;
  logic [31:0]          pt_q, pt_d;
  logic                 done_q, done_d;
  ptm_rsp_t             rsp_q, rsp_d;
  logic [31:0]          pool_base_q;

  logic                 dir_we;
  logic [DirIdxW-1:0]   dir_waddr;
  logic [31:0]          dir_wdata;
  logic [31:0]          dir_rdata;
  logic                 tbl_we;
  logic [TblAddrW-1:0]  tbl_waddr;
  logic [31:0]          tbl_wdata;
  logic [TblAddrW-1:0]  tbl_raddr;
  logic [31:0]          tbl_rdata;
  logic                 take;
  alloc_info_t          info;
  logic [31:0]          entry;

  ptm_ram #(.Width(32), .Depth(DirDepth)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (req_i.virt_addr[31:22]),
    .rdata_o (dir_rdata)
  );

  ptm_ram #(.Width(32), .Depth(TblDepth)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  ptm_alloc u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .pool_base_i (pool_base_q),
    .pde_i       (dir_rdata),
    .info_o      (info)
  );

  assign tbl_raddr = {frame_q, req_q.virt_addr[21:12]};
  assign entry     = req_q.phys_addr | TableFlags | {30'h0, req_q.writable, 1'b0};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    req_d     = req_q;
    frame_d   = frame_q;
    pt_d      = pt_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    take      = 1'b0;
    dir_we    = 1'b0;
    dir_waddr = cnt_q;
    dir_wdata = '0;
    tbl_we    = 1'b0;
    tbl_waddr = {frame_q, cnt_q};
    tbl_wdata = '0;
    unique case (state_q)
      S_INIT: begin
        dir_we    = 1'b1;
        dir_wdata = dir_reset_value(cnt_q);
        cnt_d     = cnt_q + DirIdxW'(1);
        if (cnt_q == LastSlot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.req_type == REQ_ALLOC) begin
            done_d = 1'b1;
            if (info.full) begin
              rsp_d = '{status: ST_NOMEM, frame_addr: '0, entry_value: '0};
            end else begin
              take  = 1'b1;
              rsp_d = '{status: ST_OK, frame_addr: info.addr, entry_value: '0};
            end
          end else begin
            state_d = S_DIR_CHK;
          end
        end
      end
      S_DIR_CHK: begin
        if (dir_rdata == '0) begin
          if (info.full) begin
            done_d  = 1'b1;
            rsp_d   = '{status: ST_NOMEM, frame_addr: '0, entry_value: '0};
            state_d = S_IDLE;
          end else begin
            take      = 1'b1;
            frame_d   = info.frame;
            pt_d      = info.addr;
            dir_we    = 1'b1;
            dir_waddr = req_q.virt_addr[31:22];
            dir_wdata = info.addr | PdeFlags;
            cnt_d     = '0;
            state_d   = S_CLEAR;
          end
        end else begin
          pt_d = {dir_rdata[31:12], 12'h000};
          if (!info.pde_ok) begin
            done_d  = 1'b1;
            rsp_d   = '{status: ST_BADPDE, frame_addr: {dir_rdata[31:12], 12'h000},
                        entry_value: '0};
            state_d = S_IDLE;
          end else begin
            frame_d = info.pde_frame;
            state_d = S_TBL_RD;
          end
        end
      end
      S_CLEAR: begin
        tbl_we = 1'b1;
        cnt_d  = cnt_q + DirIdxW'(1);
        if (cnt_q == DirIdxW'(TableWords - 1)) begin
          state_d = S_TBL_RD;
        end
      end
      S_TBL_RD: begin
        state_d = S_TBL_CHK;
      end
      S_TBL_CHK: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (tbl_rdata != '0) begin
          rsp_d = '{status: ST_MAPPED, frame_addr: pt_q, entry_value: '0};
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = tbl_raddr;
          tbl_wdata = entry;
          rsp_d     = '{status: ST_OK, frame_addr: pt_q, entry_value: entry};
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      pool_base_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    frame_q <= frame_d;
    pt_q    <= pt_d;
    rsp_q   <= rsp_d;
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_no_done_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !done_o)
    else $error("result during directory init");

  a_err_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.entry_value == '0))
    else $error("error result carries an entry");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_DIR_CHK || done_o))
    else $error("accepted word neither answered nor walked");

  a_tbl_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (state_q == S_CLEAR || state_q == S_TBL_CHK))
    else $error("table write outside clear or write-back");

endmodule

// ===== bench/page_table_mapper_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for page_table_mapper_core: directed table, then random words per pool base
module page_table_mapper_core_tb;
  import ptm_pkg::*;

  localparam int          RandPerPhase = 234;
  localparam int          QuietTail    = 80;
  localparam int          HotCount     = 12;
  localparam logic [31:0] PageMask     = 32'hFFFF_F000;

  typedef struct {
    ptm_req_t word;
    bit       typed;
    ptm_rsp_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        done_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  ptm_req_t    req_word;
  ptm_rsp_t    rsp_word;

  logic [31:0] dir_mem [DirDepth];
  bit   [31:0] pt_words [PoolFrames * TableWords];
  bit          frame_clean [PoolFrames];
  int unsigned next_frame;
  logic [31:0] base_reg;

  ptm_rsp_t    pending_rsp [$];
  plan_row_t   plan_q [$];
  int unsigned hot_slot [HotCount];
  int unsigned old_slots [$];
  int          n_fail = 0;

  always #4 clk_i = ~clk_i;

  page_table_mapper_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_word),
    .done_o     (done_o),
    .rsp_o      (rsp_word),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  function automatic void boot_layout();
    for (int i = 0; i < DirDepth; i++) begin
      dir_mem[i] = (i < 256) ? ((32'(i) << 22) | 32'h183) : 32'h0;
    end
    dir_mem[DirDepth - 1] = 32'h183;
    foreach (frame_clean[f]) frame_clean[f] = 1'b0;
    next_frame = 1;
    base_reg   = '0;
  endfunction

  function automatic ptm_rsp_t page_walk(ptm_req_t w);
    ptm_rsp_t    r;
    logic [31:0] de;
    logic [31:0] pt;
    logic [31:0] rel;
    int unsigned pdi;
    int unsigned pti;
    int unsigned fr;
    int unsigned idx;
    r.status      = ST_OK;
    r.frame_addr  = '0;
    r.entry_value = '0;
    if (w.req_type == REQ_ALLOC) begin
      if (next_frame >= PoolFrames) begin
        r.status = ST_NOMEM;
      end else begin
        r.frame_addr = (base_reg & PageMask) + 32'(next_frame) * 32'h1000;
        next_frame++;
      end
      return r;
    end
    pdi = 32'(w.virt_addr[31:22]);
    pti = 32'(w.virt_addr[21:12]);
    de  = dir_mem[pdi];
    if (de == 0) begin
      if (next_frame >= PoolFrames) begin
        r.status = ST_NOMEM;
        return r;
      end
      fr = next_frame;
      next_frame++;
      pt = (base_reg & PageMask) + 32'(fr) * 32'h1000;
      for (int i = 0; i < TableWords; i++) pt_words[fr * TableWords + i] = '0;
      frame_clean[fr] = 1'b1;
      dir_mem[pdi]    = pt | 32'h7;
    end else begin
      pt  = de & PageMask;
      rel = pt - (base_reg & PageMask);
      fr  = rel >> 12;
      if (fr == 0 || fr >= next_frame || fr >= PoolFrames) begin
        r.status     = ST_BADPDE;
        r.frame_addr = pt;
        return r;
      end
    end
    idx          = fr * TableWords + pti;
    r.frame_addr = pt;
    if (pt_words[idx] != 0) begin
      r.status = ST_MAPPED;
      return r;
    end
    pt_words[idx] = w.phys_addr | 32'h5 | {30'b0, w.writable, 1'b0};
    r.entry_value = pt_words[idx];
    return r;
  endfunction

  // a map through a frame that was handed out but never cleared reads undefined words
  function automatic bit lands_on_raw_frame(ptm_req_t w);
    logic [31:0] de;
    logic [31:0] rel;
    int unsigned fr;
    if (w.req_type != REQ_MAP) return 1'b0;
    de = dir_mem[w.virt_addr[31:22]];
    if (de == 0) return 1'b0;
    rel = (de & PageMask) - (base_reg & PageMask);
    fr  = rel >> 12;
    return fr != 0 && fr < next_frame && fr < PoolFrames && !frame_clean[fr];
  endfunction

  function automatic ptm_req_t make_word(int unsigned alloc_pct);
    ptm_req_t    w;
    int unsigned pick;
    int unsigned slot;
    int unsigned pti;
    w.virt_addr = $urandom;
    w.phys_addr = $urandom;
    w.writable  = 1'($urandom_range(0, 1));
    w.req_type  = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_MAP;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      slot = hot_slot[$urandom_range(0, HotCount - 1)];
    end else if (pick < 75) begin
      slot = ($urandom_range(0, 15) == 0) ? DirDepth - 1 : $urandom_range(0, 255);
    end else if (pick < 85 || old_slots.size() == 0) begin
      slot = $urandom_range(0, DirDepth - 1);
    end else begin
      slot = old_slots[$urandom_range(0, old_slots.size() - 1)];
    end
    pti = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, TableWords - 1);
    w.virt_addr[31:22] = 10'(slot);
    w.virt_addr[21:12] = 10'(pti);
    if (lands_on_raw_frame(w)) w.req_type = REQ_ALLOC;
    return w;
  endfunction

  task automatic add_row(logic rt, logic [31:0] va, logic [31:0] pa, logic wr, bit typed,
                         status_e st = ST_OK, logic [31:0] fa = '0, logic [31:0] ev = '0);
    plan_row_t row;
    row.word  = '{req_type: rt, virt_addr: va, phys_addr: pa, writable: wr};
    row.typed = typed;
    row.want  = '{status: st, frame_addr: fa, entry_value: ev};
    plan_q.push_back(row);
  endtask

  task automatic send_word(ptm_req_t w);
    start    <= 1'b1;
    req_word <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_off(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_base(logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    base_reg     = v;
  endtask

  always @(negedge clk_i) begin : check_rsp
    ptm_rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result word: status %0d frame_addr %h entry_value %h",
               rsp_word.status, rsp_word.frame_addr, rsp_word.entry_value);
        n_fail++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_word.status);
          n_fail++;
        end
        if (rsp_word.frame_addr !== want.frame_addr) begin
          $error("frame_addr: expected %h, got %h", want.frame_addr, rsp_word.frame_addr);
          n_fail++;
        end
        if (rsp_word.entry_value !== want.entry_value) begin
          $error("entry_value: expected %h, got %h", want.entry_value, rsp_word.entry_value);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL page_table_mapper_core");
    $finish;
  end

  initial begin
    ptm_rsp_t    got;
    ptm_req_t    w;
    logic [31:0] bases [4];
    bit          quiet;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_word    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    boot_layout();

    add_row(REQ_ALLOC, 32'h0,         32'h0,         1'b0, 1'b1, ST_OK, 32'h0000_1000);
    add_row(REQ_MAP,   32'h0000_0000, 32'h0,         1'b0, 1'b1, ST_BADPDE, 32'h0);
    add_row(REQ_MAP,   32'hFFC0_0000, 32'h0,         1'b1, 1'b1, ST_BADPDE, 32'h0);
    add_row(REQ_MAP,   32'h0040_0000, 32'h0,         1'b0, 1'b1, ST_BADPDE, 32'h0040_0000);
    add_row(REQ_MAP,   32'h3FC0_0000, 32'h0,         1'b1, 1'b1, ST_BADPDE, 32'h3FC0_0000);
    add_row(REQ_MAP,   32'h4000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK, 32'h2000, 32'hFFFF_FFFF);
    add_row(REQ_MAP,   32'h4000_0000, 32'h0,         1'b0, 1'b1, ST_MAPPED, 32'h2000);
    add_row(REQ_MAP,   32'h403F_FFFF, 32'h0,         1'b0, 1'b1, ST_OK, 32'h2000, 32'h5);
    add_row(REQ_MAP,   32'h4000_1ABC, 32'h1234_5000, 1'b1, 1'b1, ST_OK, 32'h2000, 32'h1234_5007);
    add_row(REQ_MAP,   32'hFF80_0000, 32'hAAAA_A000, 1'b0, 1'b0);
    add_row(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_row(REQ_MAP,   32'hFF80_0000, 32'h0F0F_0F0F, 1'b1, 1'b0);
    add_row(REQ_MAP,   32'hFFBF_F000, 32'h5555_5FFF, 1'b1, 1'b0);
    add_row(REQ_MAP,   32'h0400_0000, 32'h0,         1'b0, 1'b0);
    add_row(REQ_MAP,   32'hFF7F_F000, 32'h0,         1'b1, 1'b0);
    add_row(REQ_ALLOC, 32'h0,         32'h0,         1'b0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    foreach (plan_q[i]) begin
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 13));
      send_word(plan_q[i].word);
      got = page_walk(plan_q[i].word);
      pending_rsp.push_back(plan_q[i].typed ? plan_q[i].want : got);
    end

    // last base puts old tables back in reach; 003fe000 aliases boot slot 1 onto frame 2
    bases = '{$urandom & PageMask, 32'hFFFF_F000, 32'h003F_E000, 32'h0000_0000};
    for (int p = 0; p < 4; p++) begin
      settle();
      write_base(bases[p]);
      foreach (hot_slot[j]) begin
        hot_slot[j] = $urandom_range(256, DirDepth - 2);
        old_slots.push_back(hot_slot[j]);
      end
      for (int k = 0; k < RandPerPhase; k++) begin
        w     = make_word(p == 3 ? 50 : 10);
        quiet = (p == 3) && (k >= RandPerPhase - QuietTail);
        if (!quiet && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 13));
        send_word(w);
        pending_rsp.push_back(page_walk(w));
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASS page_table_mapper_core");
    end else begin
      $display("FAIL page_table_mapper_core");
    end
    $finish;
  end

endmodule
